>>> hdl/rvig_pkg.sv
// Shared types and constants for the radial vignette pixel block.
package rvig_pkg;

    localparam int DIM_W           = 13;
    localparam int COORD_W         = 12;
    localparam int CHAN_W          = 8;
    localparam int STR_W           = 17;
    localparam int SQ_W            = 2 * DIM_W;
    localparam int D2_W            = SQ_W + 1;
    localparam int FRAC_W          = 32;
    localparam int RAD_W           = D2_W + FRAC_W + 1;
    localparam int RATIO_W         = 29;
    localparam int MK_W            = D2_W + 2 * (RATIO_W - 1);
    localparam int PROD_W          = RATIO_W + STR_W;
    localparam int Q_SHIFT         = 16;
    localparam int SCALE_W         = PROD_W - Q_SHIFT;
    localparam int FACTOR_W        = Q_SHIFT + 1;
    localparam int CPROD_W         = CHAN_W + FACTOR_W;
    localparam int MAX_DIM_DEFAULT = 4096;

    localparam logic [FACTOR_W-1:0] ONE_Q16 = FACTOR_W'(65536);

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STRENGTH     = 2'd2;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(480);
    localparam logic [STR_W-1:0] STRENGTH_RST     = STR_W'(32768);

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

>>> hdl/radial_vignette_pixel.sv
// Radial vignette: scales each RGB pixel by its distance from the image center.
// Throughput: one pixel per cycle while the skid register is empty; the radius root is a
// 29-stage bit-per-stage compare-subtract pipeline, one stage per result bit.
// A two-entry output (register plus skid) keeps s_ready high while one result waits.
// Reset (aresetn low, synchronous): valid bits cleared, registers to 640/480/32768.
module radial_vignette_pixel
    import rvig_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pixel_out_t            m_data
);

    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM >= (1 << DIM_W)) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_CAP) begin
            r = DIM_CAP;
        end else begin
            r = d;
        end
        return r;
    endfunction

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [STR_W-1:0] strength_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= IMAGE_WIDTH_RST;
            height_reg   <= IMAGE_HEIGHT_RST;
            strength_reg <= STRENGTH_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_IMAGE_WIDTH:  width_reg    <= pwdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg   <= pwdata[DIM_W-1:0];
                CFG_STRENGTH:     strength_reg <= pwdata[STR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            CFG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            CFG_STRENGTH:     prdata = CFG_DATA_W'(strength_reg);
            default:          prdata = '0;
        endcase
    end

    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;

    assign w_clamp = clamp_dim(width_reg);
    assign h_clamp = clamp_dim(height_reg);

    // squared diagonal, follows the registers
    logic [SQ_W-1:0] wsq_reg;
    logic [SQ_W-1:0] hsq_reg;
    logic [D2_W-1:0] m2_reg;

    always_ff @(posedge aclk) begin
        wsq_reg <= SQ_W'(w_clamp) * SQ_W'(w_clamp);
        hsq_reg <= SQ_W'(h_clamp) * SQ_W'(h_clamp);
        m2_reg  <= D2_W'(wsq_reg) + D2_W'(hsq_reg);
    end

    // stall control
    logic en;
    logic skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // stage 1: doubled offsets from center
    logic [DIM_W-1:0] col2;
    logic [DIM_W-1:0] row2;
    logic             s1_vld_reg;
    logic [DIM_W-1:0] dx_reg;
    logic [DIM_W-1:0] dy_reg;
    rgb_t             s1_pix_reg;

    assign col2 = {s_data.column, 1'b0};
    assign row2 = {s_data.row, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg     <= (col2 >= w_clamp) ? col2 - w_clamp : w_clamp - col2;
            dy_reg     <= (row2 >= h_clamp) ? row2 - h_clamp : h_clamp - row2;
            s1_pix_reg <= '{s_data.red_in, s_data.green_in, s_data.blue_in};
        end
    end

    // stage 2: squares
    logic            s2_vld_reg;
    logic [SQ_W-1:0] dxsq_reg;
    logic [SQ_W-1:0] dysq_reg;
    rgb_t            s2_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dxsq_reg   <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            dysq_reg   <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            s2_pix_reg <= s1_pix_reg;
        end
    end

    // stage 3: squared distance
    logic            s3_vld_reg;
    logic [D2_W-1:0] d2_reg;
    rgb_t            s3_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg     <= D2_W'(dxsq_reg) + D2_W'(dysq_reg);
            s3_pix_reg <= s2_pix_reg;
        end
    end

    // ratio = largest r with r*r*m2 <= d2 << 32, one bit per stage, MSB first.
    // rem holds N - r*r*m2, tsh holds r*m2 << (k+1) for the bit k under trial.
    logic [RAD_W-1:0]   rem_reg  [RATIO_W-1];
    logic [RAD_W-1:0]   tsh_reg  [RATIO_W-1];
    logic [RATIO_W-1:0] root_reg [RATIO_W];
    logic               rvld_reg [RATIO_W];
    rgb_t               rpix_reg [RATIO_W];

    for (genvar i = 0; i < RATIO_W; i++) begin : g_root
        localparam int K = RATIO_W - 1 - i;

        logic [RAD_W-1:0]   rem_in;
        logic [RAD_W-1:0]   tsh_in;
        logic [RATIO_W-1:0] root_in;
        logic               vld_in;
        rgb_t               pix_in;
        logic [MK_W-1:0]    mk;
        logic               over;
        logic [RAD_W:0]     trial;
        logic               take;
        logic [RATIO_W-1:0] root_next;

        if (i == 0) begin : g_first
            assign rem_in  = RAD_W'({d2_reg, {FRAC_W{1'b0}}});
            assign tsh_in  = '0;
            assign root_in = '0;
            assign vld_in  = s3_vld_reg;
            assign pix_in  = s3_pix_reg;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign tsh_in  = tsh_reg[i-1];
            assign root_in = root_reg[i-1];
            assign vld_in  = rvld_reg[i-1];
            assign pix_in  = rpix_reg[i-1];
        end

        assign mk    = MK_W'(m2_reg) << (2 * K);
        assign over  = |mk[MK_W-1:RAD_W];
        assign trial = {1'b0, tsh_in} + {1'b0, mk[RAD_W-1:0]};
        assign take  = !over && (trial <= {1'b0, rem_in});

        always_comb begin
            root_next    = root_in;
            root_next[K] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rvld_reg[i] <= 1'b0;
            end else if (en) begin
                rvld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[i] <= root_next;
                rpix_reg[i] <= pix_in;
            end
        end

        if (i < RATIO_W - 1) begin : g_carry
            logic [RAD_W:0] tsh_next;

            assign tsh_next = {1'b0, tsh_in} +
                              (take ? {mk[RAD_W-1:0], 1'b0} : {(RAD_W + 1){1'b0}});

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= take ? rem_in - trial[RAD_W-1:0] : rem_in;
                    tsh_reg[i] <= tsh_next[RAD_W:1];
                end
            end
        end
    end

    // ratio * strength
    logic              sm_vld_reg;
    logic [PROD_W-1:0] sprod_reg;
    rgb_t              sm_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sm_vld_reg <= 1'b0;
        end else if (en) begin
            sm_vld_reg <= rvld_reg[RATIO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sprod_reg  <= PROD_W'(root_reg[RATIO_W-1]) * PROD_W'(strength_reg);
            sm_pix_reg <= rpix_reg[RATIO_W-1];
        end
    end

    // factor = 1.0 - s, floored at zero
    logic [SCALE_W-1:0]  scale;
    logic                fa_vld_reg;
    logic [FACTOR_W-1:0] factor_reg;
    rgb_t                fa_pix_reg;

    assign scale = sprod_reg[PROD_W-1:Q_SHIFT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fa_vld_reg <= 1'b0;
        end else if (en) begin
            fa_vld_reg <= sm_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            factor_reg <= (|scale[SCALE_W-1:Q_SHIFT]) ? '0 :
                          ONE_Q16 - {1'b0, scale[Q_SHIFT-1:0]};
            fa_pix_reg <= sm_pix_reg;
        end
    end

    // channel scaling; product never exceeds 255 << 16
    logic [CPROD_W-1:0] red_prod;
    logic [CPROD_W-1:0] green_prod;
    logic [CPROD_W-1:0] blue_prod;
    logic               ch_vld_reg;
    pixel_out_t         ch_reg;

    assign red_prod   = CPROD_W'(fa_pix_reg.red) * CPROD_W'(factor_reg);
    assign green_prod = CPROD_W'(fa_pix_reg.green) * CPROD_W'(factor_reg);
    assign blue_prod  = CPROD_W'(fa_pix_reg.blue) * CPROD_W'(factor_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_vld_reg <= 1'b0;
        end else if (en) begin
            ch_vld_reg <= fa_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ch_reg.red_out   <= red_prod[Q_SHIFT+CHAN_W-1:Q_SHIFT];
            ch_reg.green_out <= green_prod[Q_SHIFT+CHAN_W-1:Q_SHIFT];
            ch_reg.blue_out  <= blue_prod[Q_SHIFT+CHAN_W-1:Q_SHIFT];
        end
    end

    // output register and skid
    logic       m_valid_reg;
    pixel_out_t out_reg;
    pixel_out_t skid_reg;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= ch_vld_reg;
            end
        end else if (ch_vld_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : ch_reg;
        end
        if (!out_free && en) begin
            skid_reg <= ch_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> tb/radial_vignette_pixel_tb.sv
// Self-checking testbench for radial_vignette_pixel: directed rows, then randomized phases.
`timescale 1ns / 1ps

module radial_vignette_pixel_tb;
    import rvig_pkg::*;

    localparam int  LATENCY   = 35;
    localparam int  MAX_DIM   = MAX_DIM_DEFAULT;
    localparam int  N_PHASES  = 8;
    localparam int  PHASE_PIX = 50;

    typedef enum bit {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [1:0]       reg_idx;
        logic [31:0]      reg_val;
        pixel_in_t        pix;
        bit               pinned;
        pixel_out_t       want;
    } stim_row_t;

    typedef struct {
        bit         on;
        pixel_out_t val;
    } pin_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    pixel_in_t             s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    pixel_out_t            m_data;

    // shadow of the block's registers
    logic [DIM_W-1:0] img_w   = IMAGE_WIDTH_RST;
    logic [DIM_W-1:0] img_h   = IMAGE_HEIGHT_RST;
    logic [STR_W-1:0] img_str = STRENGTH_RST;

    pixel_out_t expected_pixels[$];
    pin_t       pinned_pixels[$];
    stim_row_t  directed_rows[$];

    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 0;

    logic [9:0] rx_tick = '0;

    always #10 aclk = ~aclk;

    radial_vignette_pixel DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic longint unsigned dim_eff(logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return 64'(d);
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] scale_chan(logic [CHAN_W-1:0] v,
                                                     longint unsigned f);
        longint unsigned p;
        p = 64'(v);
        p = (p * f) >> Q_SHIFT;
        return (p > 255) ? 8'd255 : p[CHAN_W-1:0];
    endfunction

    function automatic pixel_out_t vignette_pixel(pixel_in_t px);
        longint unsigned w, h, c2, r2, dx, dy, d2, m2, ratio, s, factor;
        pixel_out_t o;
        w  = dim_eff(img_w);
        h  = dim_eff(img_h);
        c2 = 64'(px.column);
        r2 = 64'(px.row);
        c2 = c2 * 2;
        r2 = r2 * 2;
        dx = (c2 >= w) ? c2 - w : w - c2;
        dy = (r2 >= h) ? r2 - h : h - r2;
        d2 = dx * dx + dy * dy;
        m2 = w * w + h * h;
        ratio  = root64((d2 << 32) / m2);
        s      = (ratio * 64'(img_str)) >> Q_SHIFT;
        factor = (s >= 65536) ? 0 : 65536 - s;
        o.red_out   = scale_chan(px.red_in, factor);
        o.green_out = scale_chan(px.green_in, factor);
        o.blue_out  = scale_chan(px.blue_in, factor);
        return o;
    endfunction

    function automatic stim_row_t px_row(int col, int row, int r, int g, int b,
                                         bit pinned = 0, int wr = 0, int wg = 0,
                                         int wb = 0);
        stim_row_t e;
        e.kind           = ROW_PIXEL;
        e.reg_idx        = CFG_IMAGE_WIDTH;
        e.reg_val        = '0;
        e.pix.column     = col[COORD_W-1:0];
        e.pix.row        = row[COORD_W-1:0];
        e.pix.red_in     = r[CHAN_W-1:0];
        e.pix.green_in   = g[CHAN_W-1:0];
        e.pix.blue_in    = b[CHAN_W-1:0];
        e.pinned         = pinned;
        e.want.red_out   = wr[CHAN_W-1:0];
        e.want.green_out = wg[CHAN_W-1:0];
        e.want.blue_out  = wb[CHAN_W-1:0];
        return e;
    endfunction

    function automatic stim_row_t reg_row(logic [1:0] idx, logic [31:0] val);
        stim_row_t e;
        e         = px_row(0, 0, 0, 0, 0);
        e.kind    = ROW_REG;
        e.reg_idx = idx;
        e.reg_val = val;
        return e;
    endfunction

    function automatic pixel_in_t rand_pixel();
        pixel_in_t p;
        int unsigned w, h, pick;
        w    = 32'(dim_eff(img_w));
        h    = 32'(dim_eff(img_h));
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
            p.column = COORD_W'($urandom_range(0, w - 1));
            p.row    = COORD_W'($urandom_range(0, h - 1));
        end else if (pick == 7) begin
            p.column = COORD_W'($urandom_range(0, 4095));
            p.row    = COORD_W'($urandom_range(0, 4095));
        end else if (pick == 8) begin
            case ($urandom_range(0, 3))
                0: p.column = '0;
                1: p.column = COORD_W'(w - 1);
                2: p.column = (w > 4095) ? COORD_W'(4095) : COORD_W'(w);
                default: p.column = COORD_W'(4095);
            endcase
            case ($urandom_range(0, 3))
                0: p.row = '0;
                1: p.row = COORD_W'(h - 1);
                2: p.row = (h > 4095) ? COORD_W'(4095) : COORD_W'(h);
                default: p.row = COORD_W'(4095);
            endcase
        end else begin
            p.column = COORD_W'(w / 2);
            p.row    = COORD_W'(h / 2);
        end
        if ($urandom_range(0, 7) != 0) begin
            p.red_in   = CHAN_W'($urandom_range(0, 255));
            p.green_in = CHAN_W'($urandom_range(0, 255));
            p.blue_in  = CHAN_W'($urandom_range(0, 255));
        end else begin
            p.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    // called just after a falling edge; returns just after the falling edge that follows acceptance
    task automatic send_pixel(pixel_in_t p);
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w   = val[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: img_h   = val[DIM_W-1:0];
            CFG_STRENGTH:     img_str = val[STR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver backpressure: cycles through four m_ready patterns, one never stalling, on its own schedule
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        case (rx_tick[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_tick[2:0] < 3'd5);
        endcase
    end

    // scoreboard
    always @(posedge aclk) begin
        pin_t       pin;
        pixel_out_t exp_px;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pin = pinned_pixels.pop_front();
                expected_pixels.push_back(pin.on ? pin.val : vignette_pixel(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: unexpected output transaction %h", $realtime, m_data);
                end else begin
                    exp_px = expected_pixels.pop_front();
                    n_checked++;
                    if (m_data.red_out !== exp_px.red_out ||
                        m_data.green_out !== exp_px.green_out ||
                        m_data.blue_out !== exp_px.blue_out) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("%0t: mismatch rgb exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, exp_px.red_out, exp_px.green_out,
                                     exp_px.blue_out, m_data.red_out,
                                     m_data.green_out, m_data.blue_out);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int         burst_left;
        int         gap;
        bit         gappy;
        logic [31:0] pw, ph, ps;
        pin_t       pin;

        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        s_valid = 1'b0;
        s_data  = '0;

        // default setting 640x480, strength one half
        directed_rows.push_back(px_row(320, 240, 255, 255, 255, 1, 255, 255, 255));
        directed_rows.push_back(px_row(320, 240, 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(px_row(0, 0, 255, 255, 255, 1, 127, 127, 127));
        directed_rows.push_back(px_row(640, 480, 255, 128, 1, 1, 127, 64, 0));
        directed_rows.push_back(px_row(4095, 4095, 255, 255, 255, 1, 0, 0, 0));
        directed_rows.push_back(px_row(0, 4095, 170, 85, 255));
        directed_rows.push_back(px_row(4095, 0, 1, 2, 3));
        directed_rows.push_back(px_row(100, 400, 200, 100, 50));
        directed_rows.push_back(reg_row(CFG_STRENGTH, 0));
        directed_rows.push_back(px_row(0, 0, 255, 255, 255, 1, 255, 255, 255));
        directed_rows.push_back(px_row(4095, 4095, 255, 0, 255, 1, 255, 0, 255));
        directed_rows.push_back(reg_row(CFG_STRENGTH, 65536));
        directed_rows.push_back(px_row(0, 0, 255, 255, 255, 1, 0, 0, 0));
        directed_rows.push_back(px_row(320, 240, 255, 255, 255, 1, 255, 255, 255));
        directed_rows.push_back(reg_row(CFG_STRENGTH, 131071));
        directed_rows.push_back(px_row(321, 240, 255, 255, 255));
        directed_rows.push_back(px_row(0, 0, 255, 255, 255, 1, 0, 0, 0));
        // zero dimensions behave as one
        directed_rows.push_back(reg_row(CFG_IMAGE_WIDTH, 0));
        directed_rows.push_back(reg_row(CFG_IMAGE_HEIGHT, 0));
        directed_rows.push_back(px_row(0, 0, 255, 255, 255));
        directed_rows.push_back(reg_row(CFG_STRENGTH, 16384));
        directed_rows.push_back(px_row(1, 1, 255, 255, 255));
        // oversized dimensions clamp to the maximum
        directed_rows.push_back(reg_row(CFG_IMAGE_WIDTH, 8191));
        directed_rows.push_back(reg_row(CFG_IMAGE_HEIGHT, 5000));
        directed_rows.push_back(px_row(2048, 2048, 255, 255, 255, 1, 255, 255, 255));
        directed_rows.push_back(px_row(0, 0, 9, 9, 9));
        directed_rows.push_back(px_row(4095, 4095, 255, 255, 255));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        n_settings = 1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                wait_drained();
                apb_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
                n_settings++;
            end else begin
                pin.on  = directed_rows[i].pinned;
                pin.val = directed_rows[i].want;
                pinned_pixels.push_back(pin);
                send_pixel(directed_rows[i].pix);
            end
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin pw = 640;     ph = 480;     ps = 32768;   end
                1: begin pw = 1;       ph = 1;       ps = 65536;   end
                2: begin pw = 4096;    ph = 4096;    ps = 65535;   end
                3: begin pw = 8191;    ph = 1;       ps = 131071;  end
                4: begin pw = 0;       ph = 4096;    ps = 0;       end
                5: begin pw = 'h1555;  ph = 'h0AAA;  ps = 'h15555; end
                6: begin
                    pw = $urandom_range(0, 8191);
                    ph = $urandom_range(0, 8191);
                    ps = $urandom_range(0, 131071);
                end
                default: begin
                    pw = $urandom_range(1, 32);
                    ph = $urandom_range(1, 32);
                    ps = $urandom_range(0, 65536);
                end
            endcase
            wait_drained();
            apb_write(CFG_IMAGE_WIDTH, pw);
            apb_write(CFG_IMAGE_HEIGHT, ph);
            apb_write(CFG_STRENGTH, ps);
            n_settings++;

            gappy      = (phase % 3 != 2);
            burst_left = $urandom_range(1, 16);
            for (int k = 0; k < PHASE_PIX; k++) begin
                pin.on  = 1'b0;
                pin.val = '0;
                pinned_pixels.push_back(pin);
                send_pixel(rand_pixel());
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap = gappy ? $urandom_range(0, 8) : 0;
                    if (gap > 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(negedge aclk);
                    end
                end
            end
        end

        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY + 15) @(posedge aclk);

        $display("Sent %0d pixels across %0d register settings; %0d results compared.",
                 n_sent, n_settings, n_checked);
        $display("Mismatches or stray transactions: %0d", n_errors);
        if (n_errors == 0 && expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
